@@ rtl/core/kmc_pkg.sv @@
// shared types, constants and the note key table of the keyboard to midi controller
package kmc_pkg;

   localparam int NUM_CHANNELS  = 16;
   localparam int CH_W          = $clog2(NUM_CHANNELS);
   localparam int NUM_NOTE_KEYS = 26;
   localparam int KEY_IDX_W     = $clog2(NUM_NOTE_KEYS);
   localparam int MAX_RESULTS   = 28;
   localparam int MSG_IDX_W     = $clog2(MAX_RESULTS + 1);
   localparam int DIV_STEPS     = 24;
   localparam int DIV_CNT_W     = $clog2(DIV_STEPS + 1);

   localparam logic [7:0] KEY_TAB      = 8'h2B;
   localparam logic [7:0] KEY_MINUS    = 8'h2D;
   localparam logic [7:0] KEY_EQUALS   = 8'h2E;
   localparam logic [7:0] KEY_LBRACKET = 8'h2F;
   localparam logic [7:0] KEY_RBRACKET = 8'h30;
   localparam logic [7:0] KEY_LSHIFT   = 8'hE1;
   localparam logic [7:0] KEY_RSHIFT   = 8'hE5;

   localparam logic [7:0] ST_ON   = 8'h90;
   localparam logic [7:0] ST_OFF  = 8'h80;
   localparam logic [7:0] ST_PROG = 8'hC0;
   localparam logic [7:0] ST_DRUM = 8'h99;

   localparam logic [6:0] FIRST_NOTE  = 7'd36;
   localparam logic [6:0] HIT_NOTE    = 7'd76;
   localparam logic [6:0] HIT_VEL     = 7'd100;
   localparam logic [8:0] TEMPO_MIN   = 9'd20;
   localparam logic [8:0] TEMPO_MAX   = 9'd300;
   localparam logic [8:0] TEMPO_RESET = 9'd120;

   localparam logic [1:0] TMR_PROG  = 2'd0;
   localparam logic [1:0] TMR_CHAN  = 2'd1;
   localparam logic [1:0] TMR_TEMPO = 2'd2;

   localparam logic [1:0] CSR_DELAY    = 2'd0;
   localparam logic [1:0] CSR_INTERVAL = 2'd1;
   localparam logic [1:0] CSR_TPM      = 2'd2;
   localparam logic [1:0] CSR_VELOCITY = 2'd3;

   localparam logic [7:0] KEY_TABLE [NUM_NOTE_KEYS] = '{
      8'h1D, 8'h1B, 8'h06, 8'h19, 8'h05, 8'h11, 8'h10,
      8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h0E, 8'h0F,
      8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C, 8'h18, 8'h0C, 8'h12, 8'h13
   };

   typedef enum logic [1:0] {
      DIR_IDLE = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } dir_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_KEY,
      S_TICK,
      S_SCAN,
      S_MET,
      S_DIV,
      S_OUT
   } state_type;

   typedef struct packed {
      logic load_in;
      logic key_exec;
      logic tmr_exec;
      logic scan_step;
      logic met_exec;
      logic div_step;
      logic div_load;
      logic out_pop;
   } kmc_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic key_scan;
      logic key_div;
      logic tmr_scan;
      logic tmr_last;
      logic scan_last;
      logic met_div;
      logic div_done;
      logic out_more;
      logic out_free;
      logic out_last;
   } kmc_status_type;

   typedef struct packed {
      logic [7:0] status;
      logic [6:0] data1;
      logic [6:0] data2;
   } msg_type;

   typedef struct packed {
      logic                 hit;
      logic [KEY_IDX_W-1:0] idx;
   } note_hit_type;

   function automatic note_hit_type note_lookup(input logic [7:0] key);
      note_hit_type r;
      r.hit = 1'b0;
      r.idx = '0;
      for (int i = 0; i < NUM_NOTE_KEYS; i++) begin
         if (KEY_TABLE[i] == key) begin
            r.hit = 1'b1;
            r.idx = KEY_IDX_W'(i);
         end
      end
      return r;
   endfunction

endpackage

@@ rtl/core/kmc_ctrl.sv @@
// sequencer: walks an item through key, timer, scan, metronome, divide and output phases
module kmc_ctrl import kmc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  kmc_status_type status,
   output kmc_cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_KEY;
         end
         S_KEY: begin
            if (status.is_tick) state_in = S_TICK;
            else if (status.key_scan) state_in = S_SCAN;
            else if (status.key_div) state_in = S_DIV;
            else state_in = S_OUT;
         end
         S_TICK: begin
            if (status.tmr_scan) state_in = S_SCAN;
            else if (status.tmr_last) state_in = S_MET;
         end
         S_SCAN: begin
            if (status.scan_last) state_in = status.is_tick ? S_TICK : S_OUT;
         end
         S_MET: begin
            state_in = status.met_div ? S_DIV : S_OUT;
         end
         S_DIV: begin
            if (status.div_done) state_in = S_OUT;
         end
         S_OUT: begin
            if (!status.out_more) state_in = S_IDLE;
            else if (status.out_free && status.out_last) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.load_in = req_valid;
         end
         S_KEY:  cmd.key_exec  = !status.is_tick;
         S_TICK: cmd.tmr_exec  = 1'b1;
         S_SCAN: cmd.scan_step = 1'b1;
         S_MET:  cmd.met_exec  = 1'b1;
         S_DIV: begin
            cmd.div_step = !status.div_done;
            cmd.div_load = status.div_done;
         end
         S_OUT:  cmd.out_pop = status.out_more && status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

@@ rtl/core/kmc_datapath.sv @@
// controller state, timers, held notes, tempo divider, message buffer and result register
module kmc_datapath import kmc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_command,
   input  logic [7:0]     req_keycode,
   input  logic           req_pressed,
   input  logic           csr_valid,
   output logic           csr_ready,
   input  logic [1:0]     csr_index,
   input  logic [23:0]    csr_wdata,
   input  logic           rsp_ready,
   output logic           rsp_valid,
   output logic [7:0]     rsp_midi_status,
   output logic [6:0]     rsp_midi_data1,
   output logic [6:0]     rsp_midi_data2,
   output logic           rsp_last_message,
   output logic [CH_W-1:0] rsp_channel_now,
   output logic [6:0]     rsp_program_now,
   output logic [8:0]     rsp_tempo_now,
   output logic           rsp_metronome_active,
   input  kmc_cmd_type    cmd,
   output kmc_status_type status
);

   logic                 tick_ff, tick_in;
   logic [7:0]           key_ff, key_in;
   logic                 prs_ff, prs_in;
   logic [15:0]          delay_ff, delay_in;
   logic [15:0]          interval_ff, interval_in;
   logic [23:0]          tpm_ff, tpm_in;
   logic [6:0]           vel_ff, vel_in;
   logic                 held_vld_ff [NUM_NOTE_KEYS];
   logic                 held_vld_in [NUM_NOTE_KEYS];
   logic [CH_W-1:0]      held_ch_ff [NUM_NOTE_KEYS];
   logic [CH_W-1:0]      held_ch_in [NUM_NOTE_KEYS];
   logic [6:0]           prog_ff [NUM_CHANNELS];
   logic [6:0]           prog_in [NUM_CHANNELS];
   logic [CH_W-1:0]      chan_ff, chan_in;
   logic [8:0]           tempo_ff, tempo_in;
   logic                 met_on_ff, met_on_in;
   logic [23:0]          met_cnt_ff, met_cnt_in;
   logic                 shift_ff, shift_in;
   dir_type              rdir_ff [3];
   dir_type              rdir_in [3];
   logic [15:0]          rcnt_ff [3];
   logic [15:0]          rcnt_in [3];
   logic [1:0]           tmr_idx_ff, tmr_idx_in;
   logic [KEY_IDX_W-1:0] scan_idx_ff, scan_idx_in;
   dir_type              scan_dir_ff, scan_dir_in;
   logic [23:0]          quo_ff, quo_in;
   logic [8:0]           rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   msg_type              msg_ff [MAX_RESULTS];
   msg_type              msg_in [MAX_RESULTS];
   logic [MSG_IDX_W-1:0] msg_n_ff, msg_n_in;
   logic [MSG_IDX_W-1:0] rd_ff, rd_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   msg_type              rsp_msg_ff, rsp_msg_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [CH_W-1:0]      rsp_ch_ff, rsp_ch_in;
   logic [6:0]           rsp_prog_ff, rsp_prog_in;
   logic [8:0]           rsp_tempo_ff, rsp_tempo_in;
   logic                 rsp_met_ff, rsp_met_in;

   note_hit_type         nl;
   logic                 key_timer, key_is_brk;
   logic [1:0]           key_which;
   dir_type              key_dir;
   dir_type              t_dir;
   logic                 t_fire;
   logic                 step_en;
   logic [1:0]           step_which;
   dir_type              step_dir;
   logic [KEY_IDX_W-1:0] held_addr;
   logic                 held_rd_vld;
   logic [CH_W-1:0]      held_rd_ch;
   logic                 emit_en;
   msg_type              emit_msg;
   logic                 div_start;
   logic [9:0]           trial;
   logic                 trial_ge;
   logic [6:0]           prog_next;
   logic [8:0]           tempo_next;
   logic [CH_W-1:0]      chan_next;
   logic [MSG_IDX_W-1:0] rd_last;

   // key decode
   always_comb begin
      nl         = note_lookup(key_ff);
      key_is_brk = (key_ff == KEY_LBRACKET) || (key_ff == KEY_RBRACKET);
      key_timer  = key_is_brk || (key_ff == KEY_MINUS) || (key_ff == KEY_EQUALS);
      key_which  = key_is_brk ? TMR_PROG : (shift_ff ? TMR_CHAN : TMR_TEMPO);
      key_dir    = ((key_ff == KEY_EQUALS) || (key_ff == KEY_RBRACKET)) ? DIR_UP : DIR_DOWN;
      t_dir      = rdir_ff[tmr_idx_ff];
      t_fire     = ((t_dir == DIR_UP) || (t_dir == DIR_DOWN)) && (rcnt_ff[tmr_idx_ff] <= 16'd1);
      held_addr  = cmd.scan_step ? scan_idx_ff : nl.idx;
      held_rd_vld = held_vld_ff[held_addr];
      held_rd_ch  = held_ch_ff[held_addr];
      rd_last    = msg_n_ff - MSG_IDX_W'(1);
   end

   // one repeat step, from a key press or a firing timer
   always_comb begin
      step_en    = 1'b0;
      step_which = TMR_PROG;
      step_dir   = DIR_UP;
      if (cmd.key_exec && key_timer && prs_ff) begin
         step_en    = 1'b1;
         step_which = key_which;
         step_dir   = key_dir;
      end else if (cmd.tmr_exec && t_fire) begin
         step_en    = 1'b1;
         step_which = tmr_idx_ff;
         step_dir   = t_dir;
      end
      prog_next = prog_ff[chan_ff] + ((step_dir == DIR_UP) ? 7'd1 : 7'd127);
      if (step_dir == DIR_UP) tempo_next = (tempo_ff >= TEMPO_MAX) ? TEMPO_MAX : tempo_ff + 9'd1;
      else tempo_next = (tempo_ff <= TEMPO_MIN) ? TEMPO_MIN : tempo_ff - 9'd1;
      if (scan_dir_ff == DIR_UP) begin
         chan_next = (chan_ff == CH_W'(NUM_CHANNELS - 1)) ? '0 : chan_ff + CH_W'(1);
      end else begin
         chan_next = (chan_ff == '0) ? CH_W'(NUM_CHANNELS - 1) : chan_ff - CH_W'(1);
      end
      trial    = {1'b0, rem_ff} << 1 | {9'd0, quo_ff[23]};
      trial_ge = trial >= {1'b0, tempo_ff};
   end

   always_comb begin
      tick_in     = tick_ff;
      key_in      = key_ff;
      prs_in      = prs_ff;
      delay_in    = delay_ff;
      interval_in = interval_ff;
      tpm_in      = tpm_ff;
      vel_in      = vel_ff;
      held_vld_in = held_vld_ff;
      held_ch_in  = held_ch_ff;
      prog_in     = prog_ff;
      chan_in     = chan_ff;
      tempo_in    = tempo_ff;
      met_on_in   = met_on_ff;
      met_cnt_in  = met_cnt_ff;
      shift_in    = shift_ff;
      rdir_in     = rdir_ff;
      rcnt_in     = rcnt_ff;
      tmr_idx_in  = tmr_idx_ff;
      scan_idx_in = scan_idx_ff;
      scan_dir_in = scan_dir_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      div_cnt_in  = div_cnt_ff;
      msg_in      = msg_ff;
      msg_n_in    = msg_n_ff;
      rd_in       = rd_ff;
      rsp_msg_in  = rsp_msg_ff;
      rsp_last_in = rsp_last_ff;
      rsp_ch_in   = rsp_ch_ff;
      rsp_prog_in = rsp_prog_ff;
      rsp_tempo_in = rsp_tempo_ff;
      rsp_met_in  = rsp_met_ff;
      emit_en     = 1'b0;
      emit_msg    = '0;
      div_start   = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            CSR_DELAY:    delay_in    = csr_wdata[15:0];
            CSR_INTERVAL: interval_in = csr_wdata[15:0];
            CSR_TPM:      tpm_in      = csr_wdata;
            CSR_VELOCITY: vel_in      = csr_wdata[6:0];
            default:      delay_in    = delay_ff;
         endcase
      end

      if (cmd.load_in) begin
         tick_in    = req_command;
         key_in     = req_keycode;
         prs_in     = req_pressed;
         tmr_idx_in = TMR_PROG;
         msg_n_in   = '0;
         rd_in      = '0;
      end

      if (cmd.key_exec) begin
         if (key_ff == KEY_TAB) begin
            if (prs_ff) begin
               met_on_in = !met_on_ff;
               if (!met_on_ff) begin
                  emit_en   = 1'b1;
                  emit_msg  = '{ST_DRUM, HIT_NOTE, HIT_VEL};
                  div_start = 1'b1;
               end else begin
                  met_cnt_in = '0;
               end
            end
         end else if ((key_ff == KEY_LSHIFT) || (key_ff == KEY_RSHIFT)) begin
            shift_in = prs_ff;
         end else if (key_timer) begin
            if (prs_ff) begin
               rdir_in[key_which] = key_dir;
               rcnt_in[key_which] = delay_ff;
            end else begin
               rdir_in[key_which] = DIR_IDLE;
               rcnt_in[key_which] = '0;
            end
         end else if (nl.hit) begin
            if (prs_ff) begin
               emit_en   = 1'b1;
               emit_msg  = '{ST_ON | {4'd0, chan_ff}, FIRST_NOTE + 7'(nl.idx), vel_ff};
               held_vld_in[nl.idx] = 1'b1;
               held_ch_in[nl.idx]  = chan_ff;
            end else if (held_rd_vld) begin
               emit_en   = 1'b1;
               emit_msg  = '{ST_OFF | {4'd0, held_rd_ch}, FIRST_NOTE + 7'(nl.idx), 7'd0};
               held_vld_in[nl.idx] = 1'b0;
            end
         end
      end

      if (cmd.tmr_exec) begin
         // the index stops on the tempo slot so it never points past the timers
         if (tmr_idx_ff != TMR_TEMPO) tmr_idx_in = tmr_idx_ff + 2'd1;
         if ((t_dir == DIR_UP) || (t_dir == DIR_DOWN)) begin
            rcnt_in[tmr_idx_ff] = t_fire ? interval_ff : rcnt_ff[tmr_idx_ff] - 16'd1;
         end
      end

      if (step_en) begin
         case (step_which)
            TMR_PROG: begin
               prog_in[chan_ff] = prog_next;
               emit_en  = 1'b1;
               emit_msg = '{ST_PROG | {4'd0, chan_ff}, prog_next, 7'd0};
            end
            TMR_CHAN: begin
               scan_idx_in = '0;
               scan_dir_in = step_dir;
            end
            TMR_TEMPO: tempo_in = tempo_next;
            default:   tempo_in = tempo_ff;
         endcase
      end

      // note-off for every held key, then the channel moves
      if (cmd.scan_step) begin
         if (held_rd_vld) begin
            emit_en  = 1'b1;
            emit_msg = '{ST_OFF | {4'd0, held_rd_ch}, FIRST_NOTE + 7'(scan_idx_ff), 7'd0};
            held_vld_in[scan_idx_ff] = 1'b0;
         end
         scan_idx_in = scan_idx_ff + KEY_IDX_W'(1);
         if (scan_idx_ff == KEY_IDX_W'(NUM_NOTE_KEYS - 1)) chan_in = chan_next;
      end

      if (cmd.met_exec && met_on_ff) begin
         if (met_cnt_ff <= 24'd1) begin
            emit_en   = 1'b1;
            emit_msg  = '{ST_DRUM, HIT_NOTE, HIT_VEL};
            div_start = 1'b1;
         end else begin
            met_cnt_in = met_cnt_ff - 24'd1;
         end
      end

      // restoring divide ticks_per_minute / tempo, one quotient bit per cycle
      if (div_start) begin
         quo_in     = tpm_ff;
         rem_in     = '0;
         div_cnt_in = DIV_CNT_W'(DIV_STEPS);
      end
      if (cmd.div_step) begin
         rem_in     = trial_ge ? 9'(trial - {1'b0, tempo_ff}) : trial[8:0];
         quo_in     = {quo_ff[22:0], trial_ge};
         div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
      end
      if (cmd.div_load) begin
         met_cnt_in = (quo_ff == '0) ? 24'd1 : quo_ff;
      end

      if (emit_en && (msg_n_ff < MSG_IDX_W'(MAX_RESULTS))) begin
         msg_in[msg_n_ff] = emit_msg;
         msg_n_in = msg_n_ff + MSG_IDX_W'(1);
      end

      if (cmd.out_pop) begin
         rsp_msg_in   = msg_ff[rd_ff];
         rsp_last_in  = (rd_ff == rd_last);
         rsp_ch_in    = chan_ff;
         rsp_prog_in  = prog_ff[chan_ff];
         rsp_tempo_in = tempo_ff;
         rsp_met_in   = met_on_ff;
         rd_in        = rd_ff + MSG_IDX_W'(1);
      end
      rsp_valid_in = cmd.out_pop ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff     <= 16'd300;
         interval_ff  <= 16'd100;
         tpm_ff       <= 24'd60000;
         vel_ff       <= 7'd100;
         for (int i = 0; i < NUM_NOTE_KEYS; i++) held_vld_ff[i] <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) prog_ff[i] <= '0;
         chan_ff      <= '0;
         tempo_ff     <= TEMPO_RESET;
         met_on_ff    <= 1'b0;
         met_cnt_ff   <= '0;
         shift_ff     <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            rdir_ff[i] <= DIR_IDLE;
            rcnt_ff[i] <= '0;
         end
         tmr_idx_ff   <= TMR_PROG;
         scan_idx_ff  <= '0;
         scan_dir_ff  <= DIR_IDLE;
         div_cnt_ff   <= '0;
         msg_n_ff     <= '0;
         rd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         delay_ff     <= delay_in;
         interval_ff  <= interval_in;
         tpm_ff       <= tpm_in;
         vel_ff       <= vel_in;
         held_vld_ff  <= held_vld_in;
         prog_ff      <= prog_in;
         chan_ff      <= chan_in;
         tempo_ff     <= tempo_in;
         met_on_ff    <= met_on_in;
         met_cnt_ff   <= met_cnt_in;
         shift_ff     <= shift_in;
         rdir_ff      <= rdir_in;
         rcnt_ff      <= rcnt_in;
         tmr_idx_ff   <= tmr_idx_in;
         scan_idx_ff  <= scan_idx_in;
         scan_dir_ff  <= scan_dir_in;
         div_cnt_ff   <= div_cnt_in;
         msg_n_ff     <= msg_n_in;
         rd_ff        <= rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tick_ff      <= tick_in;
      key_ff       <= key_in;
      prs_ff       <= prs_in;
      held_ch_ff   <= held_ch_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      msg_ff       <= msg_in;
      rsp_msg_ff   <= rsp_msg_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ch_ff    <= rsp_ch_in;
      rsp_prog_ff  <= rsp_prog_in;
      rsp_tempo_ff <= rsp_tempo_in;
      rsp_met_ff   <= rsp_met_in;
   end

   always_comb begin
      status.is_tick   = tick_ff;
      status.key_scan  = !tick_ff && key_timer && prs_ff && (key_which == TMR_CHAN);
      status.key_div   = !tick_ff && (key_ff == KEY_TAB) && prs_ff && !met_on_ff;
      status.tmr_scan  = t_fire && (tmr_idx_ff == TMR_CHAN);
      status.tmr_last  = (tmr_idx_ff == TMR_TEMPO);
      status.scan_last = (scan_idx_ff == KEY_IDX_W'(NUM_NOTE_KEYS - 1));
      status.met_div   = met_on_ff && (met_cnt_ff <= 24'd1);
      status.div_done  = (div_cnt_ff == '0);
      status.out_more  = (rd_ff != msg_n_ff);
      status.out_free  = !rsp_valid_ff || rsp_ready;
      status.out_last  = (rd_ff == rd_last);
   end

   assign csr_ready            = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_midi_status      = rsp_msg_ff.status;
   assign rsp_midi_data1       = rsp_msg_ff.data1;
   assign rsp_midi_data2       = rsp_msg_ff.data2;
   assign rsp_last_message     = rsp_last_ff;
   assign rsp_channel_now      = rsp_ch_ff;
   assign rsp_program_now      = rsp_prog_ff;
   assign rsp_tempo_now        = rsp_tempo_ff;
   assign rsp_metronome_active = rsp_met_ff;

endmodule

@@ rtl/core/keyboard_to_midi_controller_top.sv @@
// top level: key events and ticks in, midi messages out
// one item at a time: a key event passes the key phase, then the held-note walk over all
// 26 note keys on a channel step or the tempo divide when the metronome starts, then output
// a tick passes the key phase and the three repeat timers in turn, with the walk when the
// channel timer fires, then the metronome check and, on a hit, the tempo divide, then output
// stalls hold the output; synchronous active-high reset sets control state to its defaults
module keyboard_to_midi_controller_top import kmc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic            req_command,
   input  logic [7:0]      req_keycode,
   input  logic            req_pressed,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [1:0]      csr_index,
   input  logic [23:0]     csr_wdata,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [7:0]      rsp_midi_status,
   output logic [6:0]      rsp_midi_data1,
   output logic [6:0]      rsp_midi_data2,
   output logic            rsp_last_message,
   output logic [CH_W-1:0] rsp_channel_now,
   output logic [6:0]      rsp_program_now,
   output logic [8:0]      rsp_tempo_now,
   output logic            rsp_metronome_active
);

   kmc_cmd_type    cmd;
   kmc_status_type status;

   kmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   kmc_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_command          (req_command),
      .req_keycode          (req_keycode),
      .req_pressed          (req_pressed),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .rsp_ready            (rsp_ready),
      .rsp_valid            (rsp_valid),
      .rsp_midi_status      (rsp_midi_status),
      .rsp_midi_data1       (rsp_midi_data1),
      .rsp_midi_data2       (rsp_midi_data2),
      .rsp_last_message     (rsp_last_message),
      .rsp_channel_now      (rsp_channel_now),
      .rsp_program_now      (rsp_program_now),
      .rsp_tempo_now        (rsp_tempo_now),
      .rsp_metronome_active (rsp_metronome_active),
      .cmd                  (cmd),
      .status               (status)
   );

   // an accepted item blocks the input until its messages are out
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken twice in a row");

   // messages of one item follow each other without a gap
   a_burst_gapless: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_message) |=> rsp_valid)
      else $error("gap inside a message burst");

   a_tempo_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_tempo_now >= TEMPO_MIN && rsp_tempo_now <= TEMPO_MAX))
      else $error("tempo out of range");

   // the sequencer issues at most one command per cycle
   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_in, cmd.key_exec, cmd.tmr_exec, cmd.scan_step,
                cmd.met_exec, cmd.div_step, cmd.div_load, cmd.out_pop}))
      else $error("more than one sequencer command");

endmodule
